// ===== hdl/lbpd_pkg.sv =====
// lbpd_pkg: widths, register indexes and divider request/response types
// for the breathing led pwm duty block; no dependencies
package lbpd_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CMP_W     = 17;
	localparam int DUTY_W    = 7;
	localparam int HALF_W    = 15;
	localparam int SQ_W      = 2 * HALF_W;
	localparam int MUL_A_W   = CMP_W;
	localparam int NUM_W     = MUL_A_W + SQ_W;
	localparam int REM_W     = SQ_W + 1;
	localparam int QUO_W     = CMP_W;
	localparam int CNT_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 1'b1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] den;
		logic [CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [REM_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== hdl/led_breathing_pwm_duty_top.sv =====
// led_breathing_pwm_duty_top: breathing led pwm compare and duty from ms ticks
// depends on lbpd_pkg and lbpd_div (shared divider), one shared multiplier
//
//  channel  signals                       direction  word
//  in       in_valid in_ready now_ms      to block   32-bit ms tick
//  out      out_valid out_ready           from block compare_value, duty_pct
//           compare_value duty_pct
//  cfg      cfg_we cfg_index cfg_wdata    to block   16-bit register write
//
// an updating tick runs the phase modulo, triangle, squares and products, then
// the compare and duty divides; the modulo divides a TIME_BITS + 1 bit sum
// a tick closer than MIN_INTERVAL_MS or a period below two is taken with
// no word out; reset restores period 3000, reload 999, zero state
// in_ready is high only while idle; a finished word waits in the output
// register while the next tick is worked, and the last step stalls until
// that register frees up
module led_breathing_pwm_duty_top #(
	parameter int TIME_BITS       = 32,
	parameter int MIN_INTERVAL_MS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    now_ms,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lbpd_pkg::CMP_W-1:0]     compare_value,
	output logic [lbpd_pkg::DUTY_W-1:0]    duty_pct,
	input  logic                           cfg_we,
	input  logic [lbpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbpd_pkg::CFG_W-1:0]     cfg_wdata
);
	import lbpd_pkg::*;

	localparam int SUM_W = TIME_BITS + 1;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MOD   = 10'b0000000010,
		S_TRI   = 10'b0000000100,
		S_SQ_T  = 10'b0000001000,
		S_SQ_H  = 10'b0000010000,
		S_MUL_C = 10'b0000100000,
		S_MUL_D = 10'b0001000000,
		S_DIV_C = 10'b0010000000,
		S_DIV_D = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     period_q;
	logic [CFG_W-1:0]     reload_q;
	logic [TIME_BITS-1:0] last_q;
	logic [CFG_W-1:0]     phase_q;
	logic [HALF_W-1:0]    t_q;
	logic [HALF_W-1:0]    h_q;
	logic [SQ_W-1:0]      t2_q;
	logic [SQ_W-1:0]      h2_q;
	logic [NUM_W-1:0]     prod_q;
	logic [CMP_W-1:0]     cmp_q;
	logic [DUTY_W-1:0]    duty_q;
	logic                 out_valid_q;
	logic [CMP_W-1:0]     compare_value_q;
	logic [DUTY_W-1:0]    duty_pct_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] dt;
	logic [SUM_W-1:0]     sum;
	logic                 take;
	logic                 out_load;
	logic [HALF_W-1:0]    half;
	logic [HALF_W-1:0]    phase_h;
	logic [CFG_W-1:0]     mirror;
	logic [MUL_A_W-1:0]   mul_a;
	logic [SQ_W-1:0]      mul_b;
	logic [NUM_W-1:0]     duty_num;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign now_t   = now_ms[TIME_BITS-1:0];
	assign dt      = now_t - last_q;
	assign sum     = SUM_W'(phase_q) + SUM_W'(dt);
	assign in_ready = (state_q == S_IDLE);
	assign take    = in_valid && in_ready && (period_q >= CFG_W'(2))
	                 && (dt >= TIME_BITS'(MIN_INTERVAL_MS));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign half    = period_q[CFG_W-1:1];
	assign phase_h = phase_q[HALF_W-1:0];
	assign mirror  = {half, 1'b0} - phase_q;
	assign duty_num = prod_q + NUM_W'(h2_q);

	always_comb begin
		unique case (state_q)
			S_SQ_T:  begin mul_a = MUL_A_W'(t_q);          mul_b = SQ_W'(t_q); end
			S_SQ_H:  begin mul_a = MUL_A_W'(h_q);          mul_b = SQ_W'(h_q); end
			S_MUL_C: begin mul_a = MUL_A_W'(reload_q) + 1'b1; mul_b = t2_q;    end
			S_MUL_D: begin mul_a = MUL_A_W'(200);          mul_b = t2_q;       end
			default: begin mul_a = '0;                     mul_b = '0;         end
		endcase
	end

	always_comb begin
		div_req       = '0;
		if (take) begin
			div_req.start = 1'b1;
			div_req.num   = NUM_W'(sum) << (NUM_W - SUM_W);
			div_req.rem   = '0;
			div_req.den   = REM_W'(period_q);
			div_req.iters = CNT_W'(SUM_W);
		end else if (state_q == S_MUL_D) begin
			div_req.start = 1'b1;
			div_req.num   = prod_q << (NUM_W - CMP_W);
			div_req.rem   = REM_W'(prod_q >> CMP_W);
			div_req.den   = REM_W'(h2_q);
			div_req.iters = CNT_W'(CMP_W);
		end else if (state_q == S_DIV_C && div_rsp.done) begin
			div_req.start = 1'b1;
			div_req.num   = duty_num << (NUM_W - DUTY_W);
			div_req.rem   = REM_W'(duty_num >> DUTY_W);
			div_req.den   = {h2_q, 1'b0};
			div_req.iters = CNT_W'(DUTY_W);
		end
	end

	lbpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= CFG_W'(3000);
			reload_q <= CFG_W'(999);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_wdata;
				REG_RELOAD: reload_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						last_q  <= now_t;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (div_rsp.done) begin
						phase_q <= div_rsp.rem[CFG_W-1:0];
						state_q <= S_TRI;
					end
				end
				S_TRI:   state_q <= S_SQ_T;
				S_SQ_T:  state_q <= S_SQ_H;
				S_SQ_H:  state_q <= S_MUL_C;
				S_MUL_C: state_q <= S_MUL_D;
				S_MUL_D: state_q <= S_DIV_C;
				S_DIV_C: begin
					if (div_rsp.done)
						state_q <= S_DIV_D;
				end
				S_DIV_D: begin
					if (div_rsp.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TRI) begin
			h_q <= half;
			t_q <= (phase_q < CFG_W'(half)) ? phase_h : mirror[HALF_W-1:0];
		end
		if (state_q == S_SQ_T || state_q == S_SQ_H || state_q == S_MUL_C
		    || state_q == S_MUL_D)
			prod_q <= mul_a * mul_b;
		if (state_q == S_SQ_H)
			t2_q <= prod_q[SQ_W-1:0];
		if (state_q == S_MUL_C)
			h2_q <= prod_q[SQ_W-1:0];
		if (state_q == S_DIV_C && div_rsp.done)
			cmp_q <= div_rsp.quo;
		if (state_q == S_DIV_D && div_rsp.done)
			duty_q <= div_rsp.quo[DUTY_W-1:0];
		if (out_load) begin
			compare_value_q <= cmp_q;
			duty_pct_q      <= duty_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = compare_value_q;
	assign duty_pct      = duty_pct_q;

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_pct <= DUTY_W'(100))
		else $error("duty above 100");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_MOD || state_q == S_DIV_C || state_q == S_DIV_D))
		else $error("divider done outside a divide step");

	a_tri_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ_T |-> t_q <= h_q)
		else $error("triangle value above half period");

endmodule

// ===== hdl/lbpd_div.sv =====
// lbpd_div: shared restoring divider, one quotient bit per cycle
// depends on lbpd_pkg for widths and request/response structs
module lbpd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lbpd_pkg::div_req_t  req,
	output lbpd_pkg::div_rsp_t  rsp
);
	import lbpd_pkg::*;

	logic [NUM_W-1:0] num_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			rem_q <= req.rem;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule
